FILE: sv/pfiu_pkg.sv
// ============================================================================
// pfiu_pkg - shared types and constants for the packed face index unpacker
// Field widths, operation codes, descriptor layout and the bit length helper.
// ============================================================================
`default_nettype none

package pfiu_pkg;

    // Field widths of one input item and one result item
    localparam int OP_W     = 2;
    localparam int ADDR_W   = 12;
    localparam int BASE_W   = 12;
    localparam int COUNT_W  = 8;
    localparam int RANGE_W  = 8;
    localparam int OFFSET_W = 12;
    localparam int DATA_W   = 16;
    localparam int FACE_W   = 12;
    localparam int TCOUNT_W = 5;
    localparam int FWIDTH_W = 4;   // field width 0..8

    // Item operation codes
    typedef enum logic [OP_W-1:0] {
        OP_WR_DESC  = 2'd0,
        OP_WR_BYTE  = 2'd1,
        OP_WR_INDEX = 2'd2,
        OP_QUERY    = 2'd3
    } op_t;

    // One face-group descriptor, 40 bits
    typedef struct packed {
        logic [BASE_W-1:0]   base;
        logic [COUNT_W-1:0]  count;
        logic [RANGE_W-1:0]  range;
        logic [OFFSET_W-1:0] offset;
    } desc_t;

    // Bit length of an 8-bit value (0 for zero)
    function automatic logic [FWIDTH_W-1:0] bit_len8(input logic [7:0] v);
        logic [FWIDTH_W-1:0] n;
        n = '0;
        for (int i = 0; i < 8; i++) begin
            if (v[i])
            begin
                n = FWIDTH_W'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

`default_nettype wire

FILE: sv/packed_face_index_unpacker.sv
// ============================================================================
// packed_face_index_unpacker - face group walk and packed corner index lookup
// Holds group descriptors, a packed bit store and an index store loaded by
// write items; a query finds a face's group and returns three corner indices.
// ============================================================================
//
// Channel   Signals                                   Direction  Handshake
// -------   ----------------------------------------  ---------  --------------------
// item      start, op, addr, desc_*, write_data,      in         start & !busy
//           face_number
// result    done, found, vertex_a/b/c                 out        done strobe, 1 cycle
// config    cfg_valid, cfg_ready, cfg_data            in         cfg_valid & cfg_ready
//
// Write items are stored on acceptance and produce no result; busy stays low.
// A query walks one descriptor per cycle (descriptor memory read), then
// steps through S_ADDR, S_LO, S_HI, S_FLD, S_IRD and S_VAL for each
// corner: two packed byte reads and an index read. done follows the last
// corner on a hit and the last descriptor on a miss. Each memory has a
// single read port. The next item may be started in the done cycle.
// Reset clears control state and table_count; the stores are not cleared.
// The result side has no back-pressure; done is a one-cycle strobe.
// ============================================================================
`default_nettype none

module packed_face_index_unpacker #(
    parameter int MAX_GROUPS   = 16,
    parameter int PACKED_DEPTH = 4096,
    parameter int INDEX_DEPTH  = 4096
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // item channel
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [pfiu_pkg::OP_W-1:0]     op,
    input  wire logic [pfiu_pkg::ADDR_W-1:0]   addr,
    input  wire logic [pfiu_pkg::BASE_W-1:0]   desc_base,
    input  wire logic [pfiu_pkg::COUNT_W-1:0]  desc_count,
    input  wire logic [pfiu_pkg::RANGE_W-1:0]  desc_range,
    input  wire logic [pfiu_pkg::OFFSET_W-1:0] desc_offset,
    input  wire logic [pfiu_pkg::DATA_W-1:0]   write_data,
    input  wire logic [pfiu_pkg::FACE_W-1:0]   face_number,
    // result channel
    output logic                               done,
    output logic                               found,
    output logic [pfiu_pkg::DATA_W-1:0]        vertex_a,
    output logic [pfiu_pkg::DATA_W-1:0]        vertex_b,
    output logic [pfiu_pkg::DATA_W-1:0]        vertex_c,
    // configuration channel
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [pfiu_pkg::TCOUNT_W-1:0] cfg_data
);

    import pfiu_pkg::*;

    localparam int GW   = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int GCW  = $clog2(MAX_GROUPS + 1);
    localparam int PAW  = $clog2(PACKED_DEPTH);
    localparam int IAW  = $clog2(INDEX_DEPTH);
    localparam int POS_W  = 17;   // (4095*3+2)*8 fits
    localparam int BRAW_W = 15;   // offset + pos/8 fits
    localparam int IRAW_W = 13;   // base + field fits
    // conditional-subtract steps for the address wrap (depth >= 256)
    localparam int PK_STEPS = 6;
    localparam int IX_STEPS = 5;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_DESC = 9'b000000010,
        S_POS  = 9'b000000100,
        S_ADDR = 9'b000001000,
        S_LO   = 9'b000010000,
        S_HI   = 9'b000100000,
        S_FLD  = 9'b001000000,
        S_IRD  = 9'b010000000,
        S_VAL  = 9'b100000000
    } state_t;

    // Wrap a packed byte address into the store
    function automatic logic [PAW-1:0] wrap_pk(input logic [BRAW_W-1:0] v);
        logic [31:0] r;
        r = 32'(v);
        for (int s = PK_STEPS - 1; s >= 0; s--) begin
            if (r >= (32'(PACKED_DEPTH) << s))
            begin
                r = r - (32'(PACKED_DEPTH) << s);
            end
        end
        return PAW'(r);
    endfunction

    // Wrap an index address into the store
    function automatic logic [IAW-1:0] wrap_ix(input logic [IRAW_W-1:0] v);
        logic [31:0] r;
        r = 32'(v);
        for (int s = IX_STEPS - 1; s >= 0; s--) begin
            if (r >= (32'(INDEX_DEPTH) << s))
            begin
                r = r - (32'(INDEX_DEPTH) << s);
            end
        end
        return IAW'(r);
    endfunction

    // Memories
    desc_t             desc_mem [MAX_GROUPS];
    logic [7:0]        pk_mem   [PACKED_DEPTH];
    logic [DATA_W-1:0] ix_mem   [INDEX_DEPTH];

    desc_t             desc_q;
    logic [7:0]        pk_q;
    logic [DATA_W-1:0] ix_q;
    logic [GW-1:0]     desc_rd_addr;
    logic [PAW-1:0]    pk_rd_addr;

    // Control registers
    state_t              state_reg, state_next;
    logic [TCOUNT_W-1:0] tcount_reg;
    logic [GCW-1:0]      walk_reg, walk_next;
    logic [GCW-1:0]      g_reg, g_next;
    logic [1:0]          k_reg, k_next;
    logic                done_reg, done_next;

    // Datapath registers
    logic [FACE_W-1:0]   face_reg, face_next;
    logic [BASE_W-1:0]   base_reg, base_next;
    logic [OFFSET_W-1:0] offset_reg, offset_next;
    logic [FWIDTH_W-1:0] fw_reg, fw_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [PAW-1:0]      lo_addr_reg, lo_addr_next;
    logic [PAW-1:0]      hi_addr_reg, hi_addr_next;
    logic [2:0]          sh_reg, sh_next;
    logic [7:0]          lo_byte_reg, lo_byte_next;
    logic [IAW-1:0]      ia_reg, ia_next;
    logic                found_reg, found_next;
    logic [DATA_W-1:0]   va_reg, va_next;
    logic [DATA_W-1:0]   vb_reg, vb_next;
    logic [DATA_W-1:0]   vc_reg, vc_next;

    logic accept;
    logic is_query;
    logic [GCW-1:0]      walk_in;
    logic [13:0]         face3;
    logic [BRAW_W-1:0]   byte_raw;
    logic [PAW-1:0]      lo_addr_c;
    logic [15:0]         window;
    logic [7:0]          fmask;
    logic [7:0]          field;

    assign accept    = start && !busy;
    assign is_query  = (op_t'(op) == OP_QUERY);
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    assign done     = done_reg;
    assign found    = found_reg;
    assign vertex_a = va_reg;
    assign vertex_b = vb_reg;
    assign vertex_c = vc_reg;

    // Groups walked: table_count capped at MAX_GROUPS
    assign walk_in = (32'(tcount_reg) < MAX_GROUPS) ? GCW'(tcount_reg) : GCW'(MAX_GROUPS);

    // Read addresses
    assign desc_rd_addr = (state_reg == S_IDLE) ? '0 : GW'(g_reg + GCW'(1));
    assign pk_rd_addr   = (state_reg == S_LO) ? lo_addr_reg : hi_addr_reg;

    // Descriptor memory: write on item, read every cycle
    always_ff @(posedge clk)
    begin
        if (accept && op_t'(op) == OP_WR_DESC && 32'(addr) < MAX_GROUPS)
        begin
            desc_mem[GW'(addr)] <= '{base: desc_base, count: desc_count,
                                     range: desc_range, offset: desc_offset};
        end
        desc_q <= desc_mem[desc_rd_addr];
    end

    // Packed byte memory
    always_ff @(posedge clk)
    begin
        if (accept && op_t'(op) == OP_WR_BYTE && 32'(addr) < PACKED_DEPTH)
        begin
            pk_mem[PAW'(addr)] <= write_data[7:0];
        end
        pk_q <= pk_mem[pk_rd_addr];
    end

    // Index word memory
    always_ff @(posedge clk)
    begin
        if (accept && op_t'(op) == OP_WR_INDEX && 32'(addr) < INDEX_DEPTH)
        begin
            ix_mem[IAW'(addr)] <= write_data;
        end
        ix_q <= ix_mem[ia_reg];
    end

    // Address and field arithmetic
    assign face3     = {1'b0, face_reg, 1'b0} + {2'b00, face_reg};
    assign byte_raw  = BRAW_W'(offset_reg) + BRAW_W'(pos_reg[POS_W-1:3]);
    assign lo_addr_c = wrap_pk(byte_raw);
    assign window    = {pk_q, lo_byte_reg} >> sh_reg;
    assign fmask     = 8'((9'd1 << fw_reg) - 9'd1);
    assign field     = window[7:0] & fmask;

    // Query sequencer
    always_comb
    begin
        state_next   = state_reg;
        walk_next    = walk_reg;
        g_next       = g_reg;
        k_next       = k_reg;
        done_next    = 1'b0;
        face_next    = face_reg;
        base_next    = base_reg;
        offset_next  = offset_reg;
        fw_next      = fw_reg;
        pos_next     = pos_reg;
        lo_addr_next = lo_addr_reg;
        hi_addr_next = hi_addr_reg;
        sh_next      = sh_reg;
        lo_byte_next = lo_byte_reg;
        ia_next      = ia_reg;
        found_next   = found_reg;
        va_next      = va_reg;
        vb_next      = vb_reg;
        vc_next      = vc_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && is_query)
                begin
                    face_next = face_number;
                    walk_next = walk_in;
                    g_next    = '0;
                    va_next   = '0;
                    vb_next   = '0;
                    vc_next   = '0;
                    if (walk_in == '0)
                    begin
                        // empty table: miss at once
                        found_next = 1'b0;
                        done_next  = 1'b1;
                    end
                    else
                    begin
                        state_next = S_DESC;
                    end
                end
            end
            S_DESC:
            begin
                if (face_reg < FACE_W'(desc_q.count))
                begin
                    base_next   = desc_q.base;
                    offset_next = desc_q.offset;
                    fw_next     = bit_len8(desc_q.range - 8'd1);
                    state_next  = S_POS;
                end
                else
                begin
                    face_next = face_reg - FACE_W'(desc_q.count);
                    g_next    = g_reg + GCW'(1);
                    if (g_reg + GCW'(1) == walk_reg)
                    begin
                        found_next = 1'b0;
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            S_POS:
            begin
                // bit position of the first corner: face*3*width
                pos_next   = POS_W'(face3 * fw_reg);
                k_next     = '0;
                state_next = S_ADDR;
            end
            S_ADDR:
            begin
                lo_addr_next = lo_addr_c;
                hi_addr_next = (lo_addr_c == PAW'(PACKED_DEPTH - 1)) ? '0
                                                                      : lo_addr_c + PAW'(1);
                sh_next      = pos_reg[2:0];
                state_next   = S_LO;
            end
            S_LO:
            begin
                state_next = S_HI;
            end
            S_HI:
            begin
                lo_byte_next = pk_q;
                state_next   = S_FLD;
            end
            S_FLD:
            begin
                ia_next    = wrap_ix(IRAW_W'(field) + IRAW_W'(base_reg));
                state_next = S_IRD;
            end
            S_IRD:
            begin
                state_next = S_VAL;
            end
            S_VAL:
            begin
                case (k_reg)
                    2'd0:    va_next = ix_q;
                    2'd1:    vb_next = ix_q;
                    default: vc_next = ix_q;
                endcase
                pos_next = pos_reg + POS_W'(fw_reg);
                if (k_reg == 2'd2)
                begin
                    found_next = 1'b1;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = S_ADDR;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            tcount_reg <= '0;
            walk_reg   <= '0;
            g_reg      <= '0;
            k_reg      <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            walk_reg  <= walk_next;
            g_reg     <= g_next;
            k_reg     <= k_next;
            done_reg  <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                tcount_reg <= cfg_data;
            end
        end
    end

    // Datapath state
    always_ff @(posedge clk)
    begin
        face_reg    <= face_next;
        base_reg    <= base_next;
        offset_reg  <= offset_next;
        fw_reg      <= fw_next;
        pos_reg     <= pos_next;
        lo_addr_reg <= lo_addr_next;
        hi_addr_reg <= hi_addr_next;
        sh_reg      <= sh_next;
        lo_byte_reg <= lo_byte_next;
        ia_reg      <= ia_next;
        found_reg   <= found_next;
        va_reg      <= va_next;
        vb_reg      <= vb_next;
        vc_reg      <= vc_next;
    end

endmodule

`default_nettype wire
